[src/tsst_pkg.sv]
// Shared types and constants for the time sync source tracker.
`default_nettype none
package tsst_pkg;

    localparam int DEF_NODE_COUNT = 16;
    localparam int SENDER_SPAN    = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 280;
    localparam int M_TDATA_W = 272;

    localparam logic [7:0]  MIN_LEN_SHORT   = 8'd16;
    localparam logic [7:0]  MIN_LEN_LONG    = 8'd32;
    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd5000;

    typedef enum logic [1:0] {
        KIND_ANNOUNCE = 2'd0,
        KIND_REQUEST  = 2'd1,
        KIND_RESPONSE = 2'd2,
        KIND_OTHER    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_ANNOUNCE,
        OP_REQUEST,
        OP_RESPONSE
    } op_t;

    localparam logic [1:0] ROLE_PRIMARY = 2'd1;
    localparam logic [1:0] ROLE_BACKUP  = 2'd2;

    localparam logic [1:0] REG_SYNC_ENABLED   = 2'd0;
    localparam logic [1:0] REG_NODE_ROLE      = 2'd1;
    localparam logic [1:0] REG_SOURCE_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_OWN_ID         = 2'd3;

    typedef struct packed {
        op_t         op;
        logic [3:0]  sender;
        logic [63:0] now;
        logic [63:0] w_zero;
        logic [63:0] w_time;
        logic        side_valid;
        logic [7:0]  side;
    } tsst_item_t;

endpackage
`default_nettype wire

[src/tsst_front.sv]
// Front end: accept words, classify them and queue the kept ones.
`default_nettype none
module tsst_front
    import tsst_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  sender_id,
    input  wire logic [63:0] local_ms,
    input  wire logic [7:0]  payload_len,
    input  wire logic [63:0] word_zero,
    input  wire logic [63:0] word_one,
    input  wire logic [63:0] word_three,
    input  wire logic        side_valid,
    input  wire logic [7:0]  side,
    output logic             q_valid,
    output tsst_item_t       q_item,
    input  wire logic        q_pop
);

    tsst_item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    tsst_item_t              item;
    logic                    keep;
    logic                    push;
    logic                    pop;
    logic                    len_short_ok;
    logic                    len_long_ok;
    logic                    in_range;

    assign len_short_ok = payload_len >= MIN_LEN_SHORT;
    assign len_long_ok  = payload_len >= MIN_LEN_LONG;
    assign in_range     = int'(sender_id) < NODE_COUNT;

    always_comb
    begin
        item.op         = OP_ANNOUNCE;
        item.sender     = sender_id;
        item.now        = local_ms;
        item.w_zero     = word_zero;
        item.w_time     = word_one;
        item.side_valid = side_valid;
        item.side       = side_valid ? side : 8'd0;
        keep            = 1'b0;
        case (kind_t'(kind))
            KIND_ANNOUNCE:
            begin
                item.op = OP_ANNOUNCE;
                keep    = len_short_ok && in_range;
            end
            KIND_REQUEST:
            begin
                item.op = OP_REQUEST;
                keep    = len_short_ok;
            end
            KIND_RESPONSE:
            begin
                item.op     = OP_RESPONSE;
                item.w_time = word_three;
                keep        = len_long_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = count_reg != '0;
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

[src/tsst_back.sv]
// Back end: source tracking, time anchor and response output register.
`default_nettype none
module tsst_back
    import tsst_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire tsst_item_t  q_item,
    output logic             q_pop,
    input  wire logic        sync_enabled,
    input  wire logic [1:0]  node_role,
    input  wire logic [31:0] source_timeout,
    input  wire logic [3:0]  own_id,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      resp_seq,
    output logic [63:0]      resp_t1,
    output logic [63:0]      resp_net_ms,
    output logic [63:0]      resp_stamp,
    output logic [3:0]       resp_from,
    output logic             resp_side_valid,
    output logic [7:0]       resp_side
);

    localparam int TABLE_DEPTH = (NODE_COUNT < SENDER_SPAN) ? NODE_COUNT : SENDER_SPAN;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    logic [63:0]      last_seen_reg [TABLE_DEPTH];
    logic             have_time_reg, have_time_next;
    logic [63:0]      offset_reg, offset_next;
    logic             src_valid_reg, src_valid_next;
    logic [IDX_W-1:0] src_idx_reg, src_idx_next;
    logic [63:0]      prio_reg, prio_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      seq_reg, t1_reg, net_reg, stamp_reg;
    logic [3:0]       from_reg;
    logic             side_valid_reg;
    logic [7:0]       side_reg;

    logic [IDX_W-1:0] sender_idx;
    logic [63:0]      elapsed;
    logic             lost;
    logic             adopt;
    logic             answer;
    logic             role_ok;
    logic             slot_free;
    logic             is_announce;
    logic             is_request;
    logic             is_response;

    assign sender_idx  = q_item.sender[IDX_W-1:0];
    assign is_announce = q_item.op == OP_ANNOUNCE;
    assign is_request  = q_item.op == OP_REQUEST;
    assign is_response = q_item.op == OP_RESPONSE;
    assign role_ok     = (node_role == ROLE_PRIMARY) || (node_role == ROLE_BACKUP);
    assign answer      = is_request && sync_enabled && role_ok && have_time_reg;
    assign slot_free   = !out_valid_reg || m_tready;
    assign q_pop       = q_valid && (!is_request || slot_free);

    assign elapsed = q_item.now - last_seen_reg[src_idx_reg];
    assign lost    = src_valid_reg && (src_idx_reg != sender_idx)
                     && (elapsed > {32'd0, source_timeout});
    assign adopt   = !have_time_reg || (q_item.w_zero < prio_reg) || !src_valid_reg || lost;

    always_comb
    begin
        have_time_next = have_time_reg;
        offset_next    = offset_reg;
        src_valid_next = src_valid_reg;
        src_idx_next   = src_idx_reg;
        prio_next      = prio_reg;
        if (q_pop && ((is_announce && adopt) || is_response))
        begin
            have_time_next = 1'b1;
            offset_next    = q_item.w_time - q_item.now;
        end
        if (q_pop && is_announce && adopt)
        begin
            src_valid_next = 1'b1;
            src_idx_next   = sender_idx;
            prio_next      = q_item.w_zero;
        end
        if (q_pop && answer)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_time_reg <= 1'b0;
            offset_reg    <= '0;
            src_valid_reg <= 1'b0;
            src_idx_reg   <= '0;
            prio_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_time_reg <= have_time_next;
            offset_reg    <= offset_next;
            src_valid_reg <= src_valid_next;
            src_idx_reg   <= src_idx_next;
            prio_reg      <= prio_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && is_announce)
        begin
            last_seen_reg[sender_idx] <= q_item.now;
        end
        if (q_pop && answer)
        begin
            seq_reg        <= q_item.w_zero;
            t1_reg         <= q_item.w_time;
            net_reg        <= offset_reg + q_item.now;
            stamp_reg      <= q_item.now;
            from_reg       <= own_id;
            side_valid_reg <= q_item.side_valid;
            side_reg       <= q_item.side;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign resp_seq        = seq_reg;
    assign resp_t1         = t1_reg;
    assign resp_net_ms     = net_reg;
    assign resp_stamp      = stamp_reg;
    assign resp_from       = from_reg;
    assign resp_side_valid = side_valid_reg;
    assign resp_side       = side_reg;

endmodule
`default_nettype wire

[src/time_sync_source_tracker.sv]
// Time sync source tracker: stream ports, register file and front/back split.
// With the queue empty, an accepted request is queued, then popped and registered in
// the output register that drives m_tvalid. Throughput: one word per cycle while
// s_tready is high, set by the back end's per-word state update; a four-entry queue
// between front and back absorbs output stalls. Reset clears registers, time anchor,
// source state and queue; the last-seen table is not cleared and needs no clearing pass.
`default_nettype none
module time_sync_source_tracker
    import tsst_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sender_id[3:0], local_ms, payload_len, word_zero, word_one, word_three,
    // side_valid, side, zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // resp_seq, resp_t1, resp_net_ms, resp_stamp, resp_from, resp_side_valid,
    // resp_side, zero fill
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic        sync_enabled_reg;
    logic [1:0]  node_role_reg;
    logic [31:0] source_timeout_reg;
    logic [3:0]  own_id_reg;
    logic        cfg_write;

    logic        q_valid;
    tsst_item_t  q_item;
    logic        q_pop;

    logic [63:0] resp_seq, resp_t1, resp_net_ms, resp_stamp;
    logic [3:0]  resp_from;
    logic        resp_side_valid;
    logic [7:0]  resp_side;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_enabled_reg   <= 1'b0;
            node_role_reg      <= 2'd0;
            source_timeout_reg <= TIMEOUT_DEFAULT;
            own_id_reg         <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SYNC_ENABLED:   sync_enabled_reg   <= pwdata[0];
                REG_NODE_ROLE:      node_role_reg      <= pwdata[1:0];
                REG_SOURCE_TIMEOUT: source_timeout_reg <= pwdata;
                REG_OWN_ID:         own_id_reg         <= pwdata[3:0];
                default:            own_id_reg         <= own_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SYNC_ENABLED:   prdata = {31'd0, sync_enabled_reg};
            REG_NODE_ROLE:      prdata = {30'd0, node_role_reg};
            REG_SOURCE_TIMEOUT: prdata = source_timeout_reg;
            REG_OWN_ID:         prdata = {28'd0, own_id_reg};
            default:            prdata = 32'd0;
        endcase
    end

    tsst_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser),
        .sender_id   (s_tdata[3:0]),
        .local_ms    (s_tdata[67:4]),
        .payload_len (s_tdata[75:68]),
        .word_zero   (s_tdata[139:76]),
        .word_one    (s_tdata[203:140]),
        .word_three  (s_tdata[267:204]),
        .side_valid  (s_tdata[268]),
        .side        (s_tdata[276:269]),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    tsst_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .sync_enabled    (sync_enabled_reg),
        .node_role       (node_role_reg),
        .source_timeout  (source_timeout_reg),
        .own_id          (own_id_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .resp_seq        (resp_seq),
        .resp_t1         (resp_t1),
        .resp_net_ms     (resp_net_ms),
        .resp_stamp      (resp_stamp),
        .resp_from       (resp_from),
        .resp_side_valid (resp_side_valid),
        .resp_side       (resp_side)
    );

    assign m_tdata = {3'd0, resp_side, resp_side_valid, resp_from,
                      resp_stamp, resp_net_ms, resp_t1, resp_seq};

endmodule
`default_nettype wire
